// ===== design/rmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// RMSprop update package
// Shared types, constants and register indexes for the RMSprop update engine.
// ----------------------------------------------------------------------------
package rmsp_pkg;

  localparam int unsigned DepthDef    = 4096;
  localparam int unsigned FracBitsDef = 24;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned DataW       = 32;
  localparam int unsigned MeanW       = 31;
  localparam int unsigned CfgAddrW    = 2;
  localparam int unsigned CfgDataW    = 24;

  localparam logic [23:0] RateReset  = 24'd167772;
  localparam logic [15:0] DecayReset = 16'd58982;
  localparam logic [23:0] EpsReset   = 24'd1;

  typedef enum logic [CfgAddrW-1:0] {
    RegRate  = 2'd0,
    RegDecay = 2'd1,
    RegEps   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ModeLoad   = 1'b0,
    ModeUpdate = 1'b1
  } mode_e;

  typedef struct packed {
    logic                    mode;
    logic [IdxW-1:0]         index;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0]         index_out;
    logic signed [DataW-1:0] weight;
    logic [MeanW-1:0]        mean_square;
  } rsp_t;

  typedef struct packed {
    logic [23:0] rate;
    logic [15:0] decay;
    logic [23:0] eps;
  } cfg_t;

endpackage

// ===== design/rmsp_sqrt.sv =====
// ----------------------------------------------------------------------------
// RMSprop pipelined square root
// Restoring integer square root, two result bits per stage, with a side tag.
// ----------------------------------------------------------------------------
module rmsp_sqrt #(
  parameter int unsigned InW  = 64,
  parameter int unsigned TagW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [InW-1:0]      rad_i,
  input  logic [TagW-1:0]     tag_i,
  output logic                valid_o,
  output logic [InW/2-1:0]    root_o,
  output logic [TagW-1:0]     tag_o
);
  localparam int unsigned RootW = InW / 2;
  localparam int unsigned PerSt = 2;
  localparam int unsigned NSt   = (RootW + PerSt - 1) / PerSt;

  logic [InW-1:0]   rem_q  [NSt+1];
  logic [InW-1:0]   rad_q  [NSt+1];
  logic [RootW-1:0] res_q  [NSt+1];
  logic [TagW-1:0]  tag_q  [NSt+1];
  logic [NSt:0]     vld_q;

  always_comb begin
    rem_q[0] = '0;
    rad_q[0] = rad_i;
    res_q[0] = '0;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < NSt; s++) begin : g_st
    logic [InW-1:0]   rem_d, rad_d;
    logic [RootW-1:0] res_d;
    always_comb begin
      logic [InW+1:0] trial;
      logic [InW+1:0] rr;
      rem_d = rem_q[s];
      rad_d = rad_q[s];
      res_d = res_q[s];
      for (int k = 0; k < PerSt; k++) begin
        if (s * PerSt + k < RootW) begin
          rr    = {rem_d, rad_d[InW-1 -: 2]};
          trial = (InW+2)'({res_d, 2'b01});
          rad_d = {rad_d[InW-3:0], 2'b00};
          if (rr >= trial) begin
            rr    = rr - trial;
            res_d = {res_d[RootW-2:0], 1'b1};
          end else begin
            res_d = {res_d[RootW-2:0], 1'b0};
          end
          rem_d = rr[InW-1:0];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      rad_q[s+1] <= rad_d;
      res_q[s+1] <= res_d;
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NSt];
  assign root_o  = res_q[NSt];
  assign tag_o   = tag_q[NSt];
endmodule

// ===== design/rmsp_div.sv =====
// ----------------------------------------------------------------------------
// RMSprop pipelined divider
// Restoring unsigned division, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module rmsp_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 34,
  parameter int unsigned TagW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  input  logic [TagW-1:0]     tag_i,
  output logic                valid_o,
  output logic [NumW-1:0]     quo_o,
  output logic [TagW-1:0]     tag_o
);
  logic [DenW:0]     rem_q [NumW+1];
  logic [NumW-1:0]   num_q [NumW+1];
  logic [DenW-1:0]   den_q [NumW+1];
  logic [TagW-1:0]   tag_q [NumW+1];
  logic [NumW:0]     vld_q;

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_st
    logic [DenW+1:0] sh;
    logic [DenW:0]   rem_d;
    logic [NumW-1:0] num_d;
    always_comb begin
      sh = {rem_q[s], num_q[s][NumW-1]};
      if (sh >= {2'b00, den_q[s]}) begin
        rem_d = (DenW+1)'(sh - {2'b00, den_q[s]});
        num_d = {num_q[s][NumW-2:0], 1'b1};
      end else begin
        rem_d = sh[DenW:0];
        num_d = {num_q[s][NumW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      num_q[s+1] <= num_d;
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = num_q[NumW];
  assign tag_o   = tag_q[NumW];
endmodule

// ===== design/rmsprop_parameter_update.sv =====
// Pipeline: request register and store read, gradient square, mean, mean register, then
// NSt = ceil(((31 + FRAC_BITS + 1) / 2) / 2) root stages and NumW = 56 + max(FRAC_BITS-24, 0)
// divider stages, then the weight update and the output register.
// Throughput: one request per cycle with no gaps; busy stays low after the clearing pass.
// Same-index hazards are forwarded from the pipeline.
// Reset: registers take their reset values, then a mean clearing pass over all DEPTH entries runs
// with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// RMSprop parameter update
// Weight and mean store with pipelined mean, root, divide and weight update.
// ----------------------------------------------------------------------------
module rmsprop_parameter_update #(
  parameter int unsigned DEPTH     = rmsp_pkg::DepthDef,
  parameter int unsigned FRAC_BITS = rmsp_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rmsp_pkg::req_t                req_i,
  output logic                          done,
  output rmsp_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [rmsp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rmsp_pkg::CfgDataW-1:0] cfg_data_i
);
  import rmsp_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RadW  = 2 * ((MeanW + FRAC_BITS + 1) / 2);
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned DenW  = RootW + 1;
  localparam int unsigned UpSh  = (FRAC_BITS > 24) ? FRAC_BITS - 24 : 0;
  localparam int unsigned NumW  = 56 + UpSh;
  localparam int unsigned DnSh  = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
  localparam int unsigned DenSW = DenW + DnSh;
  // tag through root+divide: mode, index, gradient sign, |g| or load value, weight, new mean
  localparam int unsigned TagW  = 1 + AW + 1 + DataW + DataW + MeanW;
  localparam int unsigned SqSt  = (RootW + 1) / 2;
  localparam int unsigned PipeL = 4 + SqSt + NumW;
  localparam int unsigned RedW  = IdxW + 1;
  localparam int unsigned RedN  = (AW < IdxW) ? IdxW - AW + 1 : 1;

  // configuration
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rate: RateReset, decay: DecayReset, eps: EpsReset};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        RegRate:  cfg_q.rate  <= cfg_data_i;
        RegDecay: cfg_q.decay <= cfg_data_i[15:0];
        RegEps:   cfg_q.eps   <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // clearing pass over the mean store
  logic          clr_q;
  logic [AW-1:0] clr_ptr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_ptr_q <= '0;
    end else if (clr_q) begin
      clr_ptr_q <= clr_ptr_q + AW'(1);
      if (clr_ptr_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
    end
  end
  assign busy = clr_q;

  logic acc;
  assign acc = start && !busy;

  logic [DataW-1:0] wmem [DEPTH];
  logic [MeanW-1:0] mmem [DEPTH];

  // stage 1: register request, read stores
  logic             v1_q, m1_q;
  logic [AW-1:0]    i1_q;
  logic [DataW-1:0] g1_q, wr1_q;
  logic [MeanW-1:0] mr1_q;
  logic [AW-1:0]    idx_in;

  // reduce the index into the store range
  always_comb begin
    logic [RedW-1:0] x;
    x = RedW'(req_i.index);
    for (int s = RedN - 1; s >= 0; s--) begin
      if (x >= (RedW'(DEPTH) << s)) x = x - (RedW'(DEPTH) << s);
    end
    idx_in = AW'(x);
  end

  // writeback bus
  logic             wb_v;
  logic [AW-1:0]    wb_i;
  logic [DataW-1:0] wb_w;
  logic [MeanW-1:0] wb_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    m1_q  <= req_i.mode;
    i1_q  <= idx_in;
    g1_q  <= req_i.value;
    wr1_q <= wmem[idx_in];
    mr1_q <= mmem[idx_in];
    if (wb_v) begin
      wmem[wb_i] <= wb_w;
    end
    if (clr_q) begin
      mmem[clr_ptr_q] <= '0;
    end else if (wb_v) begin
      mmem[wb_i] <= wb_m;
    end
  end

  // stage 2: square of gradient, look up pending means
  logic             v2_q, m2_q, s2_q;
  logic [AW-1:0]    i2_q;
  logic [DataW-1:0] ag2_q, wr2_q;
  logic [MeanW-1:0] mr2_q;
  logic [63:0]      sq2_q;
  logic [DataW-1:0] ag1;
  assign ag1 = (m1_q == ModeUpdate && g1_q[DataW-1]) ? DataW'(-g1_q) : g1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    m2_q  <= m1_q; i2_q <= i1_q; s2_q <= g1_q[DataW-1];
    ag2_q <= ag1;  wr2_q <= wr1_q; mr2_q <= mr1_q;
    sq2_q <= 64'(ag1) * 64'(ag1);
  end

  // stage 4 and the chain of new means behind it, newest first
  logic             v4_q, m4_q, s4_q;
  logic [AW-1:0]    i4_q;
  logic [DataW-1:0] ag4_q, wr4_q;
  logic [MeanW-1:0] mn4_q;
  logic [PipeL-1:2] mhv_q;
  logic [AW-1:0]    mhi_q [2:PipeL-1];
  logic [MeanW-1:0] mhm_q [2:PipeL-1];

  logic             fh2;
  logic [MeanW-1:0] fm2;
  always_comb begin
    fh2 = 1'b0;
    fm2 = '0;
    for (int k = PipeL - 1; k >= 2; k--) begin
      if (mhv_q[k] && mhi_q[k] == i2_q) begin
        fh2 = 1'b1;
        fm2 = mhm_q[k];
      end
    end
    if (v4_q && i4_q == i2_q) begin
      fh2 = 1'b1;
      fm2 = mn4_q;
    end
  end

  // stage 3: mean
  logic             v3_q, m3_q, s3_q, fh3_q;
  logic [AW-1:0]    i3_q;
  logic [DataW-1:0] ag3_q, wr3_q;
  logic [MeanW-1:0] mr3_q, fm3_q;
  logic [47:0]      sq3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    logic [63:0] sh;
    sh = sq2_q >> FRAC_BITS;
    m3_q <= m2_q; i3_q <= i2_q; s3_q <= s2_q; ag3_q <= ag2_q;
    wr3_q <= wr2_q; mr3_q <= mr2_q; fh3_q <= fh2; fm3_q <= fm2;
    sq3_q <= (sh > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : sh[47:0];
  end

  logic [MeanW-1:0] mold3;
  always_comb begin
    if (v4_q && i4_q == i3_q) mold3 = mn4_q;
    else if (fh3_q)           mold3 = fm3_q;
    else                      mold3 = mr3_q;
  end

  logic [MeanW-1:0] mean3;
  always_comb begin
    logic [64:0] a;
    logic [48:0] m;
    a = 65'(cfg_q.decay) * 65'(mold3) + 65'(17'h10000 - 17'(cfg_q.decay)) * 65'(sq3_q);
    m = a[64:16];
    mean3 = (m > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[MeanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    m4_q <= m3_q; i4_q <= i3_q; s4_q <= s3_q; ag4_q <= ag3_q;
    wr4_q <= wr3_q;
    mn4_q <= (m3_q == ModeLoad) ? '0 : mean3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mhv_q <= '0;
    else         mhv_q <= {mhv_q[PipeL-2:2], v4_q};
  end
  always_ff @(posedge clk_i) begin
    mhi_q[2] <= i4_q; mhm_q[2] <= mn4_q;
    for (int k = 3; k < PipeL; k++) begin
      mhi_q[k] <= mhi_q[k-1]; mhm_q[k] <= mhm_q[k-1];
    end
  end

  // root
  logic             sq_v;
  logic [RootW-1:0] root;
  logic [TagW-1:0]  sq_tag;
  rmsp_sqrt #(.InW(RadW), .TagW(TagW)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (v4_q),
    .rad_i   (RadW'({mn4_q, {FRAC_BITS{1'b0}}})),
    .tag_i   ({m4_q, i4_q, s4_q, ag4_q, wr4_q, mn4_q}),
    .valid_o (sq_v), .root_o (root), .tag_o (sq_tag)
  );
  logic [DenW-1:0]  den;
  always_comb begin
    den = DenW'(root) + DenW'(cfg_q.eps);
    if (den == '0) den = DenW'(1);
  end
  logic [DataW-1:0] agq;
  assign agq = sq_tag[MeanW+DataW+DataW-1 -: DataW];

  logic            dv;
  logic [NumW-1:0] q;
  logic [TagW-1:0] dtag;
  rmsp_div #(.NumW(NumW), .DenW(DenSW), .TagW(TagW)) u_div (
    .clk_i, .rst_ni,
    .valid_i (sq_v),
    .num_i   (NumW'((64'(cfg_q.rate) * 64'(agq)) << UpSh)),
    .den_i   (DenSW'(DenSW'(den) << DnSh)),
    .tag_i   (sq_tag),
    .valid_o (dv), .quo_o (q), .tag_o (dtag)
  );

  // final stage: apply step, forward weights from recent same-index results
  logic             f_m, f_s;
  logic [AW-1:0]    f_i;
  logic [DataW-1:0] f_ag, f_wr;
  logic [MeanW-1:0] f_mn;
  assign {f_m, f_i, f_s, f_ag, f_wr, f_mn} = dtag;

  logic [PipeL:1]   hv_q;
  logic [AW-1:0]    hi_q [1:PipeL];
  logic [DataW-1:0] hw_q [1:PipeL];

  logic [DataW-1:0] w_old;
  always_comb begin
    w_old = f_wr;
    for (int k = PipeL; k >= 1; k--) begin
      if (hv_q[k] && hi_q[k] == f_i) begin
        w_old = hw_q[k];
      end
    end
  end

  logic [DataW-1:0] w_new;
  always_comb begin
    logic [NumW-1:0]  qq;
    logic signed [35:0] w;
    qq = (q > NumW'(64'h2_0000_0000)) ? NumW'(64'h2_0000_0000) : q;
    w  = f_s ? 36'($signed(w_old)) + $signed({2'b00, qq[33:0]})
             : 36'($signed(w_old)) - $signed({2'b00, qq[33:0]});
    if (w > 36'sh0_7FFF_FFFF) w_new = 32'h7FFF_FFFF;
    else if (w < -36'sh0_8000_0000) w_new = 32'h8000_0000;
    else w_new = w[31:0];
  end

  logic             o_v;
  logic [AW-1:0]    o_i;
  logic [DataW-1:0] o_w;
  logic [MeanW-1:0] o_m;
  always_comb begin
    o_v = dv;
    o_i = f_i;
    if (f_m == ModeLoad) begin
      o_w = f_ag;
      o_m = '0;
    end else begin
      o_w = w_new;
      o_m = f_mn;
    end
  end
  assign wb_v = o_v;
  assign wb_i = o_i;
  assign wb_w = o_w;
  assign wb_m = o_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
    end else begin
      hv_q <= {hv_q[PipeL-1:1], o_v};
    end
  end
  always_ff @(posedge clk_i) begin
    hi_q[1] <= o_i; hw_q[1] <= o_w;
    for (int k = 2; k <= PipeL; k++) begin
      hi_q[k] <= hi_q[k-1]; hw_q[k] <= hw_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done <= 1'b0;
    else         done <= o_v;
  end
  always_ff @(posedge clk_i) begin
    rsp_o.index_out   <= IdxW'(o_i);
    rsp_o.weight      <= o_w;
    rsp_o.mean_square <= o_m;
  end
endmodule
